// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eht assertion failed");

// Next-cycle implication, disabled during reset.
`define EHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eht assertion failed");

// Next-cycle implication, active during reset too.
`define EHT_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("eht assertion failed");

`endif

// File: hw/rtl/eht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eht_pkg;

  localparam int SLOTS      = 3;
  localparam int MAX_DEPTH  = 8;
  localparam int KEY_BYTES  = 8;
  localparam int VALUE_BITS = 32;

  localparam int KEY_W   = 64;
  localparam int HASH_W  = 32;
  localparam int DIR_AW  = MAX_DEPTH;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int DIDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HCNT_W  = 3;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [HASH_W-1:0]     hash;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  typedef slot_t [SLOTS-1:0] row_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] ld;
    logic [CNT_W-1:0]   cnt;
  } meta_t;

  typedef struct packed {
    logic              dir_we;
    logic [DIR_AW-1:0] dir_addr;
    logic [DIR_AW-1:0] dir_wdata;
    logic              meta_we;
    logic [DIR_AW-1:0] meta_addr;
    meta_t             meta_wdata;
    logic              row_we;
    logic [DIR_AW-1:0] row_addr;
    row_t              row_wdata;
  } mem_req_t;

  function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             alive;
    logic [7:0]       b;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      b     = k[KEY_W-1-8*i -: 8];
      alive = alive && (b != 8'd0) && (i < KEY_BYTES);
      if (alive) r[KEY_W-1-8*i -: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [DIR_AW-1:0] dir_mask(input logic [DEPTH_W-1:0] g);
    logic [DIR_AW:0] m;
    m = ((DIR_AW+1)'(1) << g) - (DIR_AW+1)'(1);
    return m[DIR_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/extendible_hash_table_core.sv
// Extendible hash table, one request at a time.
// Input channel: in_action, in_key, in_value under in_valid / in_stall.
// Result channel: out_status, out_found_value under out_valid / out_stall.
// Every accepted beat yields exactly one result beat, in order.
// Each request is hashed one key byte per cycle until the hash signals done,
// then the directory entry is read, then the bucket row and metadata, then a
// check state decides the result, and the result register loads from the done
// state. No new request is taken until the last result has gone to that register.
// A bucket split first, when the directory doubles, copies each entry into the
// upper half, then re-points entries over the whole directory, reading and
// writing each one, then writes the two buckets; the insert then retries from
// the directory read; the single-port directory sets the cost.
// After reset a clearing pass over all 256 entries zeroes directory and bucket
// metadata; in_stall stays high during it.
// The result sits in an output register; while out_stall is high it holds,
// and a finished request waits for that register before the next beat.
`timescale 1ns / 1ps
`default_nettype none

module extendible_hash_table_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_action,
  input  wire logic [eht_pkg::KEY_W-1:0]      in_key,
  input  wire logic [eht_pkg::VALUE_BITS-1:0] in_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_status,
  output logic [eht_pkg::VALUE_BITS-1:0]      out_found_value
);
  import eht_pkg::*;

  typedef enum logic [12:0] {
    S_CLR    = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_HASH   = 13'b0000000000100,
    S_DIR    = 13'b0000000001000,
    S_BKT    = 13'b0000000010000,
    S_CHK    = 13'b0000000100000,
    S_DBL_RD = 13'b0000001000000,
    S_DBL_WR = 13'b0000010000000,
    S_PT_RD  = 13'b0000100000000,
    S_PT_WR  = 13'b0001000000000,
    S_SPL_B  = 13'b0010000000000,
    S_SPL_NB = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DIR_AW-1:0]      i_r, i_nxt;
  logic [DEPTH_W-1:0]     g_r, g_nxt;
  logic [DIR_AW:0]        nfb_r, nfb_nxt;
  action_t                act_r, act_nxt;
  logic [KEY_W-1:0]       ck_r, ck_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [DIR_AW-1:0]      b_r, b_nxt;
  row_t                   row_r, row_nxt;
  logic [DEPTH_W-1:0]     ld_r, ld_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0]  res_found_r, res_found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0]  out_found_r, out_found_nxt;

  mem_req_t               req;
  logic [DIR_AW-1:0]      dir_rdata;
  meta_t                  meta_rdata;
  row_t                   row_rdata;
  logic                   hash_start;
  logic [HASH_W-1:0]      hash;
  logic                   hash_done;

  logic                   in_fire;
  logic [SLOT_W-1:0]      hit_idx;
  logic                   hit_any;
  row_t                   ins_row, rem_row, upd_row, keep_row, move_row;
  logic [CNT_W-1:0]       kc, mc;
  logic [DIR_AW-1:0]      old_n;
  logic [DIDX_W-1:0]      ldx;

  eht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (canon_key(in_key)),
    .hash  (hash),
    .done  (hash_done)
  );

  eht_tables u_tables (
    .clk        (clk),
    .req        (req),
    .dir_rdata  (dir_rdata),
    .meta_rdata (meta_rdata),
    .row_rdata  (row_rdata)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign hash_start = in_fire;
  assign old_n      = DIR_AW'(1) << g_r;
  assign ldx        = ld_r[DIDX_W-1:0];

  // lookup in the bucket just read
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if ((CNT_W'(s) < meta_rdata.cnt) && (row_rdata[s].key == ck_r)) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    ins_row = row_rdata;
    ins_row[meta_rdata.cnt[SLOT_W-1:0]] = '{key: ck_r, hash: hash, value: val_r};
    upd_row = row_rdata;
    upd_row[hit_idx].value = val_r;
    rem_row = row_rdata;
    for (int s = 0; s < SLOTS - 1; s++) begin
      if (SLOT_W'(s) >= hit_idx) rem_row[s] = row_rdata[s+1];
    end
  end

  // split: partition by hash bit at the old local depth
  always_comb begin
    keep_row = row_r;
    move_row = row_r;
    kc = '0;
    mc = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (row_r[s].hash[ldx]) begin
        move_row[mc[SLOT_W-1:0]] = row_r[s];
        mc = mc + CNT_W'(1);
      end else begin
        keep_row[kc[SLOT_W-1:0]] = row_r[s];
        kc = kc + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    g_nxt          = g_r;
    nfb_nxt        = nfb_r;
    act_nxt        = act_r;
    ck_nxt         = ck_r;
    val_nxt        = val_r;
    b_nxt          = b_r;
    row_nxt        = row_r;
    ld_nxt         = ld_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    req            = '0;

    case (state_r)
      S_CLR: begin
        req.dir_we    = 1'b1;
        req.dir_addr  = i_r;
        req.meta_we   = 1'b1;
        req.meta_addr = i_r;
        i_nxt         = i_r + DIR_AW'(1);
        if (i_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = action_t'(in_action);
          ck_nxt    = canon_key(in_key);
          val_nxt   = in_value;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) state_nxt = S_DIR;
      end
      S_DIR: begin
        req.dir_addr = hash[DIR_AW-1:0] & dir_mask(g_r);
        state_nxt    = S_BKT;
      end
      S_BKT: begin
        b_nxt         = dir_rdata;
        req.meta_addr = dir_rdata;
        req.row_addr  = dir_rdata;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        row_nxt        = row_rdata;
        ld_nxt         = meta_rdata.ld;
        res_found_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
        req.meta_addr  = b_r;
        req.row_addr   = b_r;
        if (act_r == ACT_INSERT) begin
          if (hit_any) begin
            res_status_nxt = ST_DUPLICATE;
          end else if (meta_rdata.cnt < CNT_W'(SLOTS)) begin
            req.row_we     = 1'b1;
            req.row_wdata  = ins_row;
            req.meta_we    = 1'b1;
            req.meta_wdata = '{ld: meta_rdata.ld, cnt: meta_rdata.cnt + CNT_W'(1)};
          end else if ((meta_rdata.ld >= DEPTH_W'(MAX_DEPTH)) || nfb_r[DIR_AW]) begin
            res_status_nxt = ST_FULL;
          end else if (meta_rdata.ld >= g_r) begin
            i_nxt     = '0;
            state_nxt = S_DBL_RD;
          end else begin
            i_nxt     = '0;
            state_nxt = S_PT_RD;
          end
        end else if (!hit_any) begin
          res_status_nxt = ST_MISSING;
        end else if (act_r == ACT_SEARCH) begin
          res_found_nxt = row_rdata[hit_idx].value;
        end else if (act_r == ACT_REMOVE) begin
          req.row_we     = 1'b1;
          req.row_wdata  = rem_row;
          req.meta_we    = 1'b1;
          req.meta_wdata = '{ld: meta_rdata.ld, cnt: meta_rdata.cnt - CNT_W'(1)};
        end else begin
          req.row_we    = 1'b1;
          req.row_wdata = upd_row;
        end
      end
      S_DBL_RD: begin
        req.dir_addr = i_r;
        state_nxt    = S_DBL_WR;
      end
      S_DBL_WR: begin
        req.dir_we    = 1'b1;
        req.dir_addr  = i_r + old_n;
        req.dir_wdata = dir_rdata;
        if (i_r == old_n - DIR_AW'(1)) begin
          g_nxt     = g_r + DEPTH_W'(1);
          i_nxt     = '0;
          state_nxt = S_PT_RD;
        end else begin
          i_nxt     = i_r + DIR_AW'(1);
          state_nxt = S_DBL_RD;
        end
      end
      S_PT_RD: begin
        req.dir_addr = i_r;
        state_nxt    = S_PT_WR;
      end
      S_PT_WR: begin
        req.dir_addr  = i_r;
        req.dir_wdata = nfb_r[DIR_AW-1:0];
        req.dir_we    = (dir_rdata == b_r) && i_r[ldx];
        if (i_r == dir_mask(g_r)) begin
          state_nxt = S_SPL_B;
        end else begin
          i_nxt     = i_r + DIR_AW'(1);
          state_nxt = S_PT_RD;
        end
      end
      S_SPL_B: begin
        req.row_we     = 1'b1;
        req.row_addr   = b_r;
        req.row_wdata  = keep_row;
        req.meta_we    = 1'b1;
        req.meta_addr  = b_r;
        req.meta_wdata = '{ld: ld_r + DEPTH_W'(1), cnt: kc};
        state_nxt      = S_SPL_NB;
      end
      S_SPL_NB: begin
        req.row_we     = 1'b1;
        req.row_addr   = nfb_r[DIR_AW-1:0];
        req.row_wdata  = move_row;
        req.meta_we    = 1'b1;
        req.meta_addr  = nfb_r[DIR_AW-1:0];
        req.meta_wdata = '{ld: ld_r + DEPTH_W'(1), cnt: mc};
        nfb_nxt        = nfb_r + (DIR_AW+1)'(1);
        state_nxt      = S_DIR;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      i_r         <= '0;
      g_r         <= '0;
      nfb_r       <= (DIR_AW+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      g_r         <= g_nxt;
      nfb_r       <= nfb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    ck_r         <= ck_nxt;
    val_r        <= val_nxt;
    b_r          <= b_nxt;
    row_r        <= row_nxt;
    ld_r         <= ld_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

endmodule

`default_nettype wire

// File: hw/rtl/eht_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module eht_hash (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [eht_pkg::KEY_W-1:0] key,
  output logic [eht_pkg::HASH_W-1:0]     hash,
  output logic                           done
);
  import eht_pkg::*;

  logic [KEY_W-1:0]  key_r,  key_nxt;
  logic [HASH_W-1:0] h_r,    h_nxt;
  logic [HCNT_W-1:0] cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [7:0]        byte_c;

  assign byte_c = key_r[KEY_W-1 -: 8];

  always_comb begin
    key_nxt  = key_r;
    h_nxt    = h_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      key_nxt  = key;
      h_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // h*31 + byte; zero bytes only trail a canonical key
      if (byte_c != 8'd0) h_nxt = (h_r << 5) - h_r + HASH_W'(byte_c);
      key_nxt = key_r << 8;
      cnt_nxt = cnt_r + HCNT_W'(1);
      if (cnt_r == HCNT_W'(7)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    key_r <= key_nxt;
    h_r   <= h_nxt;
    cnt_r <= cnt_nxt;
  end

  assign hash = h_r;
  assign done = done_r;

endmodule

`default_nettype wire

// File: hw/rtl/eht_tables.sv
`timescale 1ns / 1ps
`default_nettype none

module eht_tables (
  input  wire logic                       clk,
  input  wire eht_pkg::mem_req_t          req,
  output logic [eht_pkg::DIR_AW-1:0]      dir_rdata,
  output eht_pkg::meta_t                  meta_rdata,
  output eht_pkg::row_t                   row_rdata
);
  import eht_pkg::*;

  localparam int ENTRIES = 1 << DIR_AW;

  logic [DIR_AW-1:0] dir_mem  [ENTRIES];
  meta_t             meta_mem [ENTRIES];
  row_t              row_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.dir_we) dir_mem[req.dir_addr] <= req.dir_wdata;
    dir_rdata <= dir_mem[req.dir_addr];
  end

  always_ff @(posedge clk) begin
    if (req.meta_we) meta_mem[req.meta_addr] <= req.meta_wdata;
    meta_rdata <= meta_mem[req.meta_addr];
  end

  always_ff @(posedge clk) begin
    if (req.row_we) row_mem[req.row_addr] <= req.row_wdata;
    row_rdata <= row_mem[req.row_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/eht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module eht_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [1:0]                     out_status,
  input wire logic [eht_pkg::VALUE_BITS-1:0] out_found_value
);
  import eht_pkg::*;

  `EHT_ASSERT_NXT_ALL(a_reset_no_beat, !rst_n, !out_valid)
  `EHT_ASSERT_IMP(a_found_only_ok, out_valid && (out_status != ST_OK), out_found_value == '0)
  `EHT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_found_value))

endmodule

bind extendible_hash_table_core eht_checker u_eht_checker (.*);

`default_nettype wire
